// ===== design/utf8sd_pkg.sv =====
// utf8sd_pkg: types and constants shared by the utf8 string decoder files
// no dependencies

package utf8sd_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int MAX_SEQ_BYTES = 4;

   localparam int BYTE_W = 8;
   localparam int CP_W = 21;
   localparam int CHAR_CNT_W = 16;
   localparam int MAX_CHARS_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_ONLY = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHARS = 1'b1;

   localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RESET = 16'hFFFF;

   localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_LEAD = 3'b010,
      PH_CONT = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type                kind;
      logic [CP_W-1:0]         code_point;
      logic [CHAR_CNT_W-1:0]   char_count;
      logic                    terminator_fits;
      logic                    last;
   } result_type;

endpackage

// ===== design/utf8sd_req_if.sv =====
// utf8sd_req_if: byte channel into the utf8 string decoder
// depends on utf8sd_pkg

interface utf8sd_req_if
   import utf8sd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              first;

   modport source (output valid, output in_byte, output first, input ready);
   modport sink (input valid, input in_byte, input first, output ready);
endinterface

// ===== design/utf8sd_rsp_if.sv =====
// utf8sd_rsp_if: result channel out of the utf8 string decoder
// depends on utf8sd_pkg

interface utf8sd_rsp_if
   import utf8sd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   kind_type              kind;
   logic [CP_W-1:0]       code_point;
   logic [CHAR_CNT_W-1:0] char_count;
   logic                  terminator_fits;
   logic                  last;

   modport source (output valid, output kind, output code_point, output char_count,
                   output terminator_fits, output last, input ready);
   modport sink (input valid, input kind, input code_point, input char_count,
                 input terminator_fits, input last, output ready);
endinterface

// ===== design/utf8_string_decoder.sv =====
// utf8_string_decoder: byte-serial utf8 string decoder, top level
// depends on utf8sd_pkg, utf8sd_req_if and utf8sd_rsp_if
//
// One byte is taken per clock unless input is stalled. A byte is registered on acceptance,
// decoded once the result queue has room, and its results land in a four-entry result queue.
// Outside count-only mode, a byte that finishes a character exactly at the max_chars
// capacity gives two results (the character and the end of string); the queue drains one
// result per cycle while the result side is ready, so then input stalls only when such bytes
// arrive faster than the queue can drain them. A byte is decoded only when the queue has two
// free entries, which is what stalls input when the result side holds off. Configuration
// writes take effect from the next byte decoded.

module utf8_string_decoder
   import utf8sd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   utf8sd_req_if.sink             req_chan,
   utf8sd_rsp_if.source           rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CMP_W = (COUNT_BITS > CHAR_CNT_W) ? COUNT_BITS : CHAR_CNT_W;

   logic                     count_only_ff;
   logic [MAX_CHARS_W-1:0]   max_chars_ff;

   logic                     in_valid_ff;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     in_first_ff;

   phase_type                phase_ff, phase_in, phase_eff;
   logic [1:0]               bytes_left_ff, bytes_left_in, bytes_left_eff;
   logic [CP_W-1:0]          acc_ff, acc_in, acc_eff;
   logic [COUNT_BITS-1:0]    conv_ff, conv_in, conv_eff, conv_inc;

   result_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]    count_ff;

   logic                     proc;
   logic                     pop;
   logic [1:0]               n_wr;
   result_type               res0, res1;
   logic [2:0]               lead_len;
   logic [6:0]               lead_bits;
   logic                     emit;
   logic [CP_W-1:0]          emit_cp;
   logic [CP_W-1:0]          acc_shift;
   logic [1:0]               bytes_dec;
   logic                     below_eff;
   logic                     full_inc;
   logic                     fits;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_only_ff <= 1'b0;
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT_ONLY: count_only_ff <= csr_wdata[0];
            CSR_MAX_CHARS:  max_chars_ff <= csr_wdata[MAX_CHARS_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   assign proc = in_valid_ff && (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_chan.ready = !in_valid_ff || proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
         in_first_ff <= req_chan.first;
      end
   end

   // lead byte classification
   always_comb begin
      lead_len = 3'd0;
      lead_bits = 7'd0;
      unique case (in_byte_ff) inside
         8'b0???????: begin
            lead_len = 3'd1;
            lead_bits = in_byte_ff[6:0];
         end
         8'b110?????: begin
            lead_len = 3'd2;
            lead_bits = 7'(in_byte_ff & LEAD2_MASK);
         end
         8'b1110????: begin
            lead_len = 3'd3;
            lead_bits = 7'(in_byte_ff & LEAD3_MASK);
         end
         8'b11110???: begin
            lead_len = 3'd4;
            lead_bits = 7'(in_byte_ff & LEAD4_MASK);
         end
         default: begin
            lead_len = 3'd0;
            lead_bits = 7'd0;
         end
      endcase
   end

   // decode of one byte
   always_comb begin
      phase_eff = in_first_ff ? PH_LEAD : phase_ff;
      conv_eff = in_first_ff ? '0 : conv_ff;
      bytes_left_eff = in_first_ff ? 2'd0 : bytes_left_ff;
      acc_eff = in_first_ff ? '0 : acc_ff;

      conv_inc = (conv_eff == '1) ? conv_eff : conv_eff + COUNT_BITS'(1);
      below_eff = CMP_W'(conv_eff) < CMP_W'(max_chars_ff);
      full_inc = CMP_W'(conv_inc) >= CMP_W'(max_chars_ff);
      fits = !count_only_ff && below_eff;
      acc_shift = {acc_eff[CP_W-7:0], 6'(in_byte_ff & CONT_MASK)};
      bytes_dec = bytes_left_eff - 2'd1;

      phase_in = phase_ff;
      bytes_left_in = bytes_left_ff;
      acc_in = acc_ff;
      conv_in = conv_ff;
      n_wr = 2'd0;
      res0 = '0;
      res1 = '0;
      emit = 1'b0;
      emit_cp = '0;

      if (proc) begin
         phase_in = phase_eff;
         bytes_left_in = bytes_left_eff;
         acc_in = acc_eff;
         conv_in = conv_eff;
         unique case (phase_eff)
            PH_LEAD: begin
               if (in_byte_ff == '0 || (!count_only_ff && !below_eff)) begin
                  res0.kind = KIND_END;
                  res0.char_count = CHAR_CNT_W'(CMP_W'(conv_eff));
                  res0.terminator_fits = fits;
                  res0.last = 1'b1;
                  n_wr = 2'd1;
                  phase_in = PH_IDLE;
                  bytes_left_in = 2'd0;
                  acc_in = '0;
               end else if (lead_len == 3'd0 || lead_len > 3'(MAX_SEQ_BYTES)) begin
                  res0.kind = KIND_ERROR;
                  res0.char_count = CHAR_CNT_W'(CMP_W'(conv_eff));
                  res0.last = 1'b1;
                  n_wr = 2'd1;
                  phase_in = PH_IDLE;
                  bytes_left_in = 2'd0;
                  acc_in = '0;
               end else if (lead_len == 3'd1) begin
                  emit = 1'b1;
                  emit_cp = CP_W'(lead_bits);
               end else begin
                  acc_in = CP_W'(lead_bits);
                  bytes_left_in = 2'(lead_len - 3'd1);
                  phase_in = PH_CONT;
               end
            end
            PH_CONT: begin
               acc_in = acc_shift;
               bytes_left_in = bytes_dec;
               if (bytes_dec == 2'd0) begin
                  emit = 1'b1;
                  emit_cp = acc_shift;
               end
            end
            PH_IDLE: ;
            default: phase_in = PH_IDLE;
         endcase

         if (emit) begin
            conv_in = conv_inc;
            phase_in = PH_LEAD;
            bytes_left_in = 2'd0;
            acc_in = '0;
            if (!count_only_ff) begin
               res0.kind = KIND_CHAR;
               res0.code_point = emit_cp;
               res0.char_count = CHAR_CNT_W'(CMP_W'(conv_inc));
               res0.last = !full_inc;
               n_wr = 2'd1;
               if (full_inc) begin
                  res1.kind = KIND_END;
                  res1.char_count = CHAR_CNT_W'(CMP_W'(conv_inc));
                  res1.last = 1'b1;
                  n_wr = 2'd2;
                  phase_in = PH_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bytes_left_ff <= 2'd0;
         acc_ff <= '0;
         conv_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         bytes_left_ff <= bytes_left_in;
         acc_ff <= acc_in;
         conv_ff <= conv_in;
      end
   end

   // result queue
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(n_wr);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(pop);
         count_ff <= count_ff + FIFO_CNT_W'(n_wr) - FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_wr == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= res1;
      end
   end

   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.kind = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.code_point = fifo_ff[rd_ptr_ff].code_point;
   assign rsp_chan.char_count = fifo_ff[rd_ptr_ff].char_count;
   assign rsp_chan.terminator_fits = fifo_ff[rd_ptr_ff].terminator_fits;
   assign rsp_chan.last = fifo_ff[rd_ptr_ff].last;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_cont_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CONT |-> bytes_left_ff != 2'd0)
      else $error("continuation phase with no bytes left");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (acc_ff == '0 && bytes_left_ff == 2'd0))
      else $error("idle phase with live sequence state");

   a_count_only_silent: assert property (@(posedge clock) disable iff (reset)
      (proc && count_only_ff && n_wr != 2'd0) |-> res0.kind != KIND_CHAR)
      else $error("character result in count-only mode");

   a_drop_after_end: assert property (@(posedge clock) disable iff (reset)
      (proc && phase_ff == PH_IDLE && !in_first_ff) |-> n_wr == 2'd0)
      else $error("result from a dropped byte");
`endif

endmodule

// ===== bench/tb_utf8_string_decoder.sv =====
// tb_utf8_string_decoder: self-checking bench for the byte-serial utf8 string decoder
// drives directed and random byte strings, predicts every result and checks each field
// depends on utf8sd_pkg, utf8sd_req_if, utf8sd_rsp_if and utf8_string_decoder

module tb_utf8_string_decoder;
   import utf8sd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT = 40;
   localparam int N_DIRECTED = 25;
   localparam int COUNT_ONLY_RUN = 30;

   typedef enum {ROW_PREDICTED, ROW_NO_RESULT, ROW_ONE_RESULT} row_check_type;

   typedef struct {
      logic [BYTE_W-1:0] in_byte;
      logic              first;
      row_check_type     check;
      result_type        res;
   } stim_row_type;

   bit                     clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   utf8sd_req_if req_if ();
   utf8sd_rsp_if rsp_if ();

   utf8_string_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow registers and decoder state
   bit                              cfg_count_only = 1'b0;
   logic [MAX_CHARS_W-1:0]          cfg_max_chars = MAX_CHARS_RESET;
   phase_type                       dec_phase = PH_IDLE;
   logic [1:0]                      dec_bytes_left = '0;
   logic [CP_W-1:0]                 dec_acc = '0;
   logic [COUNT_BITS_DEFAULT-1:0]   dec_converted = '0;

   result_type   byte_results[$];
   result_type   awaited_results[$];
   stim_row_type directed_rows [0:N_DIRECTED-1];

   bit          idling_on = 1'b1;
   int          hold_left = 0;
   int unsigned cycle_count = 0;
   int          mismatches = 0;
   int          results_checked = 0;
   int          bytes_sent = 0;
   int          settings_used = 1;

   function automatic result_type result_of(kind_type k, logic [CP_W-1:0] cp,
                                             logic [CHAR_CNT_W-1:0] cnt, logic fits,
                                             logic lst);
      result_type r;
      r.kind = k;
      r.code_point = cp;
      r.char_count = cnt;
      r.terminator_fits = fits;
      r.last = lst;
      return r;
   endfunction

   function automatic void close_string();
      logic fits;
      fits = !cfg_count_only && (dec_converted < cfg_max_chars);
      byte_results.push_back(result_of(KIND_END, '0, dec_converted[CHAR_CNT_W-1:0], fits, 1'b0));
      dec_phase = PH_IDLE;
      dec_bytes_left = '0;
      dec_acc = '0;
   endfunction

   function automatic void finish_char(logic [CP_W-1:0] cp);
      if (dec_converted != '1)
         dec_converted = dec_converted + 1'b1;
      dec_phase = PH_LEAD;
      dec_bytes_left = '0;
      dec_acc = '0;
      if (!cfg_count_only) begin
         byte_results.push_back(result_of(KIND_CHAR, cp, dec_converted[CHAR_CNT_W-1:0],
                                          1'b0, 1'b0));
         if (dec_converted >= cfg_max_chars)
            close_string();
      end
   endfunction

   function automatic void lead_byte(logic [BYTE_W-1:0] b);
      int              seq_len;
      logic [CP_W-1:0] bits;
      if (b == '0 || (!cfg_count_only && dec_converted >= cfg_max_chars)) begin
         close_string();
         return;
      end
      casez (b)
         8'b0???????: begin seq_len = 1; bits = CP_W'(b); end
         8'b110?????: begin seq_len = 2; bits = CP_W'(b & LEAD2_MASK); end
         8'b1110????: begin seq_len = 3; bits = CP_W'(b & LEAD3_MASK); end
         8'b11110???: begin seq_len = 4; bits = CP_W'(b & LEAD4_MASK); end
         default: begin seq_len = 0; bits = '0; end
      endcase
      if (seq_len == 0 || seq_len > MAX_SEQ_BYTES) begin
         byte_results.push_back(result_of(KIND_ERROR, '0, dec_converted[CHAR_CNT_W-1:0],
                                          1'b0, 1'b0));
         dec_phase = PH_IDLE;
         dec_bytes_left = '0;
         dec_acc = '0;
      end else if (seq_len == 1) begin
         finish_char(bits);
      end else begin
         dec_acc = bits;
         dec_bytes_left = 2'(seq_len - 1);
         dec_phase = PH_CONT;
      end
   endfunction

   // results that one accepted byte causes, in order
   function automatic void decode_byte(logic [BYTE_W-1:0] b, logic f);
      byte_results.delete();
      if (f) begin
         dec_converted = '0;
         dec_bytes_left = '0;
         dec_acc = '0;
         dec_phase = PH_LEAD;
      end
      case (dec_phase)
         PH_LEAD: lead_byte(b);
         PH_CONT: begin
            dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
            dec_bytes_left = dec_bytes_left - 1'b1;
            if (dec_bytes_left == '0)
               finish_char(dec_acc);
         end
         default: ;
      endcase
      if (byte_results.size() != 0)
         byte_results[byte_results.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic deliver_byte(input logic [BYTE_W-1:0] b, input logic f);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.first <= f;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_predicted(input logic [BYTE_W-1:0] b, input logic f);
      deliver_byte(b, f);
      decode_byte(b, f);
      foreach (byte_results[k])
         awaited_results.push_back(byte_results[k]);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit co, input logic [MAX_CHARS_W-1:0] mc);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_COUNT_ONLY;
      csr_wdata <= CSR_DATA_W'(co);
      @(posedge clock);
      csr_index <= CSR_MAX_CHARS;
      csr_wdata <= CSR_DATA_W'(mc);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_count_only = co;
      cfg_max_chars = mc;
      settings_used++;
   endtask

   // mostly well-formed strings with random content, some noise and broken sequences
   task automatic send_random_string();
      int               n_chars;
      int               seq_len;
      bit               first_due;
      bit               broken;
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] cont;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 4))
            send_predicted(8'($urandom), $urandom_range(0, 3) == 0);
         return;
      end
      n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      first_due = ($urandom_range(0, 9) != 0);
      broken = 1'b0;
      for (int c = 0; c < n_chars && !broken; c++) begin
         seq_len = $urandom_range(1, 4);
         case (seq_len)
            1: lead = 8'($urandom_range(1, 127));
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
         endcase
         if ($urandom_range(0, 99) < 6) begin
            lead = $urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
            seq_len = 1;
         end
         send_predicted(lead, first_due);
         first_due = 1'b0;
         for (int k = 1; k < seq_len && !broken; k++) begin
            if ($urandom_range(0, 99) < 4) begin
               broken = 1'b1;
            end else begin
               cont = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
               send_predicted(cont, 1'b0);
            end
         end
      end
      if (!broken && $urandom_range(0, 3) != 0)
         send_predicted(8'h00, first_due);
   endtask

   task automatic run_phase(input bit co, input logic [MAX_CHARS_W-1:0] mc, input int n_bytes);
      int start;
      configure(co, mc);
      start = bytes_sent;
      while (bytes_sent - start < n_bytes)
         send_random_string();
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
         hold_left <= $urandom_range(0, 14);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind = rsp_if.kind;
         got.code_point = rsp_if.code_point;
         got.char_count = rsp_if.char_count;
         got.terminator_fits = rsp_if.terminator_fits;
         got.last = rsp_if.last;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d cp %h count %0d",
                                      got.kind, got.code_point, got.char_count));
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (got !== want)
               report_mismatch($sformatf(
                  "got kind %0d cp %h count %0d fits %b last %b, want %0d %h %0d %b %b",
                  got.kind, got.code_point, got.char_count, got.terminator_fits, got.last,
                  want.kind, want.code_point, want.char_count, want.terminator_fits,
                  want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("FAIL utf8_string_decoder");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.in_byte = '0;
      req_if.first = 1'b0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_COUNT_ONLY;
      csr_wdata = '0;

      directed_rows = '{
         '{8'hFF, 1'b0, ROW_NO_RESULT, '0},
         '{8'h00, 1'b1, ROW_ONE_RESULT, result_of(KIND_END, '0, 16'd0, 1'b1, 1'b1)},
         '{8'h41, 1'b0, ROW_NO_RESULT, '0},
         '{8'h41, 1'b1, ROW_ONE_RESULT, result_of(KIND_CHAR, 21'h41, 16'd1, 1'b0, 1'b1)},
         '{8'h7F, 1'b0, ROW_ONE_RESULT, result_of(KIND_CHAR, 21'h7F, 16'd2, 1'b0, 1'b1)},
         '{8'hC2, 1'b0, ROW_PREDICTED, '0},
         '{8'h80, 1'b0, ROW_PREDICTED, '0},
         '{8'hDF, 1'b0, ROW_PREDICTED, '0},
         '{8'hBF, 1'b0, ROW_PREDICTED, '0},
         '{8'hEF, 1'b0, ROW_PREDICTED, '0},
         '{8'hBF, 1'b0, ROW_PREDICTED, '0},
         '{8'hBF, 1'b0, ROW_PREDICTED, '0},
         '{8'hF7, 1'b0, ROW_PREDICTED, '0},
         '{8'hBF, 1'b0, ROW_PREDICTED, '0},
         '{8'hBF, 1'b0, ROW_PREDICTED, '0},
         '{8'hBF, 1'b0, ROW_PREDICTED, '0},
         '{8'hC3, 1'b0, ROW_PREDICTED, '0},
         '{8'h00, 1'b0, ROW_PREDICTED, '0},
         '{8'hE2, 1'b0, ROW_PREDICTED, '0},
         '{8'h61, 1'b1, ROW_ONE_RESULT, result_of(KIND_CHAR, 21'h61, 16'd1, 1'b0, 1'b1)},
         '{8'h80, 1'b0, ROW_ONE_RESULT, result_of(KIND_ERROR, '0, 16'd1, 1'b0, 1'b1)},
         '{8'h41, 1'b0, ROW_NO_RESULT, '0},
         '{8'hF8, 1'b1, ROW_ONE_RESULT, result_of(KIND_ERROR, '0, 16'd0, 1'b0, 1'b1)},
         '{8'hFF, 1'b1, ROW_ONE_RESULT, result_of(KIND_ERROR, '0, 16'd0, 1'b0, 1'b1)},
         '{8'h00, 1'b1, ROW_ONE_RESULT, result_of(KIND_END, '0, 16'd0, 1'b1, 1'b1)}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         deliver_byte(directed_rows[i].in_byte, directed_rows[i].first);
         decode_byte(directed_rows[i].in_byte, directed_rows[i].first);
         case (directed_rows[i].check)
            ROW_ONE_RESULT: awaited_results.push_back(directed_rows[i].res);
            ROW_NO_RESULT: ;
            default: foreach (byte_results[k]) awaited_results.push_back(byte_results[k]);
         endcase
      end

      // zero capacity, capacity reached by a character, capacity lowered mid-string
      configure(1'b0, 16'd0);
      send_predicted(8'h41, 1'b1);
      send_predicted(8'h42, 1'b0);
      configure(1'b0, 16'd1);
      send_predicted(8'h41, 1'b1);
      configure(1'b0, 16'd3);
      send_predicted(8'h61, 1'b1);
      send_predicted(8'h62, 1'b0);
      configure(1'b0, 16'd1);
      send_predicted(8'h63, 1'b0);

      run_phase(1'b0, MAX_CHARS_RESET, 180);
      run_phase(1'b0, 16'd0, 40);
      run_phase(1'b0, 16'd1, 60);
      run_phase(1'b0, 16'($urandom_range(2, 6)), 120);
      run_phase(1'b1, 16'($urandom), 120);
      run_phase(1'b0, 16'($urandom_range(7, 65535)), 100);

      // count-only string sent back to back with no idling
      idling_on <= 1'b0;
      configure(1'b1, MAX_CHARS_RESET);
      send_predicted(8'h41, 1'b1);
      repeat (COUNT_ONLY_RUN) send_predicted(8'($urandom_range(1, 127)), 1'b0);
      send_predicted(8'h00, 1'b0);

      run_phase(1'b0, MAX_CHARS_RESET, 150);
      settle();

      $display("sent %0d bytes under %0d register settings, checked %0d results",
               bytes_sent, settings_used, results_checked);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("PASS utf8_string_decoder");
      end else begin
         $display("FAIL utf8_string_decoder");
      end
      $finish;
   end

endmodule
